// ----- sv/tsss_pkg.sv -----
// shared types and constants of the tick, sleep and semaphore scheduler
package tsss_pkg;

    localparam int PROC_COUNT_DEF = 16;
    localparam int PID_W          = 4;
    localparam int KIND_W         = 3;
    localparam int CODE_W         = 2;
    localparam int STATUS_W       = 2;
    localparam int TICKS_W        = 16;
    localparam int TIME_W         = 32;
    localparam int SLICE_W        = 16;
    localparam int SEM_ID_W       = 4;
    localparam int SEM_COUNT_W    = 8;
    localparam int WAITQ_DEPTH    = 16;
    localparam int SEM_FILL_W     = $clog2(WAITQ_DEPTH + 1);
    localparam int CMDQ_DEPTH     = 2;

    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = KIND_W;
    localparam int OUT_DATA_W = 8;
    localparam int OUT_USER_W = CODE_W;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_SLICE_LIMIT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SEM_ID      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SEM_INITIAL = 2'd2;

    localparam logic [SLICE_W-1:0]     SLICE_LIMIT_RESET = 16'd10;
    localparam logic [SEM_ID_W-1:0]    SEM_ID_RESET      = 4'd1;
    localparam logic [SEM_COUNT_W-1:0] SEM_INIT_RESET    = 8'd1;
    localparam logic [SEM_COUNT_W-1:0] SEM_COUNT_MAX     = 8'hFF;

    // command kinds on the input stream
    localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SLEEP  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WAIT   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POST   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CREATE = 3'd4;

    // per-process status
    localparam logic [STATUS_W-1:0] ST_READY = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SLEEP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_WAIT  = 2'd2;

    // result codes
    localparam logic [CODE_W-1:0] CODE_DONE   = 2'd0;
    localparam logic [CODE_W-1:0] CODE_READY  = 2'd1;
    localparam logic [CODE_W-1:0] CODE_BADSEM = 2'd2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_TICK,
        OP_SLEEP,
        OP_WAIT,
        OP_POST,
        OP_CREATE,
        OP_BADSEM
    } t_op;

    typedef struct packed {
        t_op                op;
        logic               run_ok;
        logic [PID_W-1:0]   rp;
        logic [PID_W-1:0]   tp;
        logic [TICKS_W-1:0] ticks;
    } t_cmd;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_RUN,
        B_FLUSH
    } t_bstate;

    typedef struct packed {
        logic [SEM_FILL_W-1:0]  sem_fill;
        logic [SEM_COUNT_W-1:0] sem_count;
    } t_back_stat;

endpackage

// ----- sv/tick_sleep_semaphore_scheduler.sv -----
// top level: configuration registers, front end, command queue and execution engine
//
// Kernel helper for process sleep, time slicing and one counting semaphore. Each input
// beat is one command; every command answers with one or more result beats, the final one
// marked by tlast, and each readied pid is reported for the external ready queue. A
// command beat is taken into a two-entry queue while the engine is still busy, and a
// result register lets the engine move on while a result waits. Sleep, wait, post, create
// and undefined kinds go from the idle state to the flush state. A tick visits one process
// slot per cycle through the status and wake-time tables, held while a readied slot has no
// room for its result, then updates the running pid's run count in the run state and gives
// the final result in the flush state; a stalled output holds the engine. The semaphore
// count loads 1 at reset; a write to register 2 is taken but does not change the count.
module tick_sleep_semaphore_scheduler #(
    parameter int PROC_COUNT = tsss_pkg::PROC_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [3:0] running_pid, [4] has_running, [8:5] target_pid, [24:9] sleep_ticks,
    // [28:25] sem_number, [31:29] zero
    input  logic [tsss_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [2:0] kind
    input  logic [tsss_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [3:0] ready_pid, [4] running_cleared, [7:5] zero
    output logic [tsss_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // [1:0] code
    output logic [tsss_pkg::OUT_USER_W-1:0]  m_axis_tuser,
    output logic                             m_axis_tlast,
    input  logic                             i_cfg_we,
    input  logic [tsss_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [tsss_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import tsss_pkg::*;

    logic [SLICE_W-1:0]  r_slice_limit;
    logic [SEM_ID_W-1:0] r_sem_id;

    logic       w_push;
    t_cmd       w_push_cmd;
    logic       w_full;
    logic       w_q_valid;
    t_cmd       w_q_cmd;
    logic       w_q_pop;
    logic [CODE_W-1:0] w_code;
    logic [PID_W-1:0]  w_pid;
    logic       w_cleared;
    t_back_stat w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_limit <= SLICE_LIMIT_RESET;
            r_sem_id      <= SEM_ID_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SLICE_LIMIT: r_slice_limit <= i_cfg_data[SLICE_W-1:0];
                CFG_SEM_ID:      r_sem_id      <= i_cfg_data[SEM_ID_W-1:0];
                // count is loaded only by reset
                CFG_SEM_INITIAL: begin
                end
                default: begin
                end
            endcase
        end
    end

    tsss_front #(
        .PROC_COUNT(PROC_COUNT)
    ) u_front (
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_sem_id      (r_sem_id),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd)
    );

    tsss_cmd_fifo u_cmd_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_cmd (w_push_cmd),
        .o_full     (w_full),
        .o_valid    (w_q_valid),
        .o_cmd      (w_q_cmd),
        .i_pop      (w_q_pop)
    );

    tsss_back #(
        .PROC_COUNT(PROC_COUNT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_cmd       (w_q_cmd),
        .o_q_pop       (w_q_pop),
        .i_slice_limit (r_slice_limit),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_code    (w_code),
        .o_out_pid     (w_pid),
        .o_out_cleared (w_cleared),
        .o_out_last    (m_axis_tlast),
        .o_stat        (w_stat)
    );

    assign m_axis_tdata = {3'b000, w_cleared, w_pid};
    assign m_axis_tuser = w_code;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.sem_fill <= SEM_FILL_W'(WAITQ_DEPTH))
        else $error("semaphore waiter ring overfilled");

    a_wait_needs_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stat.sem_fill != '0) |-> (w_stat.sem_count == '0))
        else $error("semaphore has waiters while count is nonzero");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            ((w_stat.sem_fill == $past(w_stat.sem_fill))
             || (w_stat.sem_fill == $past(w_stat.sem_fill) + SEM_FILL_W'(1))
             || (w_stat.sem_fill == $past(w_stat.sem_fill) - SEM_FILL_W'(1))))
        else $error("waiter ring fill changed by more than one");

endmodule

// ----- sv/tsss_front.sv -----
// front end: takes command beats and classifies them into queue entries
module tsss_front #(
    parameter int PROC_COUNT = tsss_pkg::PROC_COUNT_DEF
) (
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // running_pid, has_running, target_pid, sleep_ticks, sem_number, zero fill
    input  logic [tsss_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // kind
    input  logic [tsss_pkg::IN_USER_W-1:0]   s_axis_tuser,
    input  logic [tsss_pkg::SEM_ID_W-1:0]    i_sem_id,
    input  logic                             i_full,
    output logic                             o_push,
    output tsss_pkg::t_cmd                   o_cmd
);
    import tsss_pkg::*;

    logic [PID_W-1:0]    w_rp;
    logic                w_has;
    logic [PID_W-1:0]    w_tp;
    logic [TICKS_W-1:0]  w_ticks;
    logic [SEM_ID_W-1:0] w_sn;
    logic                w_sem_ok;
    logic                w_tp_ok;

    assign w_rp    = s_axis_tdata[3:0];
    assign w_has   = s_axis_tdata[4];
    assign w_tp    = s_axis_tdata[8:5];
    assign w_ticks = s_axis_tdata[24:9];
    assign w_sn    = s_axis_tdata[28:25];

    assign w_sem_ok = (w_sn == i_sem_id);
    assign w_tp_ok  = (int'(w_tp) < PROC_COUNT);

    assign s_axis_tready = i_rst_n && !i_full;
    assign o_push        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        o_cmd.run_ok = w_has && (int'(w_rp) < PROC_COUNT);
        o_cmd.rp     = w_rp;
        o_cmd.tp     = w_tp;
        o_cmd.ticks  = w_ticks;
        unique case (s_axis_tuser)
            KIND_TICK:   o_cmd.op = OP_TICK;
            KIND_SLEEP:  o_cmd.op = OP_SLEEP;
            KIND_WAIT:   o_cmd.op = w_sem_ok ? OP_WAIT : OP_BADSEM;
            KIND_POST:   o_cmd.op = w_sem_ok ? OP_POST : OP_BADSEM;
            // create on a slot that does not exist does nothing
            KIND_CREATE: o_cmd.op = w_tp_ok ? OP_CREATE : OP_NOP;
            default:     o_cmd.op = OP_NOP;
        endcase
    end

endmodule

// ----- sv/tsss_cmd_fifo.sv -----
// short command queue between the front end and the execution engine
module tsss_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tsss_pkg::t_cmd i_push_cmd,
    output logic           o_full,
    output logic           o_valid,
    output tsss_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import tsss_pkg::*;

    localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CMDQ_DEPTH - 1);

    t_cmd             r_mem [CMDQ_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full   = (r_count == CNT_W'(CMDQ_DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_cmd    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ----- sv/tsss_back.sv -----
// execution engine: process table, os time, semaphore and result register
module tsss_back #(
    parameter int PROC_COUNT = tsss_pkg::PROC_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_valid,
    input  tsss_pkg::t_cmd                   i_q_cmd,
    output logic                             o_q_pop,
    input  logic [tsss_pkg::SLICE_W-1:0]     i_slice_limit,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [tsss_pkg::CODE_W-1:0]      o_out_code,
    output logic [tsss_pkg::PID_W-1:0]       o_out_pid,
    output logic                             o_out_cleared,
    output logic                             o_out_last,
    output tsss_pkg::t_back_stat             o_stat
);
    import tsss_pkg::*;

    // pids are four bits wide, so no more slots than that can ever be named
    localparam int SLOTS    = (PROC_COUNT < (1 << PID_W)) ? PROC_COUNT : (1 << PID_W);
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int WQ_PTR_W = $clog2(WAITQ_DEPTH);

    t_bstate r_state, n_state;
    t_cmd    r_cmd, n_cmd;

    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [TIME_W-1:0]      r_os_time, n_os_time;
    logic [SEM_COUNT_W-1:0] r_sem_count, n_sem_count;
    logic [WQ_PTR_W-1:0]    r_sem_head, n_sem_head;
    logic [WQ_PTR_W-1:0]    r_sem_tail, n_sem_tail;
    logic [SEM_FILL_W-1:0]  r_sem_fill, n_sem_fill;

    logic               r_pend_valid, n_pend_valid;
    logic [CODE_W-1:0]  r_pend_code, n_pend_code;
    logic [PID_W-1:0]   r_pend_pid, n_pend_pid;
    logic               r_pend_clr, n_pend_clr;

    logic               r_out_valid, n_out_valid;
    logic [CODE_W-1:0]  r_out_code, n_out_code;
    logic [PID_W-1:0]   r_out_pid, n_out_pid;
    logic               r_out_clr, n_out_clr;
    logic               r_out_last, n_out_last;

    logic [STATUS_W-1:0] r_status  [SLOTS];
    logic [TIME_W-1:0]   r_wake    [SLOTS];
    logic [TICKS_W-1:0]  r_run     [SLOTS];
    logic [PID_W-1:0]    r_waiters [WAITQ_DEPTH];

    logic                st_we;
    logic [IDX_W-1:0]    st_addr;
    logic [STATUS_W-1:0] st_val;
    logic                wk_we;
    logic [IDX_W-1:0]    wk_addr;
    logic [TIME_W-1:0]   wk_val;
    logic                rt_we;
    logic [IDX_W-1:0]    rt_addr;
    logic [TICKS_W-1:0]  rt_val;
    logic                wq_we;

    logic                w_can_push;
    logic                w_pend_free;
    logic                w_scan_hit;
    logic                w_scan_stall;
    logic [IDX_W-1:0]    w_run_addr;
    logic [TICKS_W-1:0]  w_run_next;
    logic                w_run_tick;
    logic                w_preempt;
    logic                w_run_stall;
    logic [PID_W-1:0]    w_head_pid;
    logic                w_head_ok;

    assign w_can_push   = !r_out_valid || i_out_ready;
    assign w_pend_free  = !r_pend_valid || w_can_push;

    assign w_scan_hit   = (r_status[r_idx] == ST_SLEEP) && (r_wake[r_idx] <= r_os_time);
    assign w_scan_stall = w_scan_hit && !w_pend_free;

    assign w_run_addr   = r_cmd.rp[IDX_W-1:0];
    assign w_run_next   = r_run[w_run_addr] + TICKS_W'(1);
    assign w_run_tick   = r_cmd.run_ok && (r_cmd.rp != '0);
    assign w_preempt    = (w_run_next >= i_slice_limit);
    assign w_run_stall  = w_run_tick && w_preempt && !w_pend_free;

    assign w_head_pid   = r_waiters[r_sem_head];
    assign w_head_ok    = (int'(w_head_pid) < SLOTS);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    n_state = (i_q_cmd.op == OP_TICK) ? B_SCAN : B_FLUSH;
                end
            end
            B_SCAN: begin
                if (!w_scan_stall && (r_idx == IDX_W'(SLOTS - 1))) begin
                    n_state = B_RUN;
                end
            end
            B_RUN: begin
                if (!w_run_stall) begin
                    n_state = B_FLUSH;
                end
            end
            B_FLUSH: begin
                if (w_can_push) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // datapath and table writes
    always_comb begin
        o_q_pop      = 1'b0;
        n_cmd        = r_cmd;
        n_idx        = r_idx;
        n_os_time    = r_os_time;
        n_sem_count  = r_sem_count;
        n_sem_head   = r_sem_head;
        n_sem_tail   = r_sem_tail;
        n_sem_fill   = r_sem_fill;
        n_pend_valid = r_pend_valid;
        n_pend_code  = r_pend_code;
        n_pend_pid   = r_pend_pid;
        n_pend_clr   = r_pend_clr;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_code   = r_out_code;
        n_out_pid    = r_out_pid;
        n_out_clr    = r_out_clr;
        n_out_last   = r_out_last;
        st_we   = 1'b0;
        st_addr = r_idx;
        st_val  = ST_READY;
        wk_we   = 1'b0;
        wk_addr = i_q_cmd.rp[IDX_W-1:0];
        wk_val  = '0;
        rt_we   = 1'b0;
        rt_addr = w_run_addr;
        rt_val  = '0;
        wq_we   = 1'b0;

        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop      = 1'b1;
                    n_cmd        = i_q_cmd;
                    n_pend_valid = 1'b1;
                    n_pend_code  = CODE_DONE;
                    n_pend_pid   = '0;
                    n_pend_clr   = 1'b0;
                    unique case (i_q_cmd.op)
                        OP_TICK: begin
                            n_os_time    = r_os_time + TIME_W'(1);
                            n_idx        = '0;
                            n_pend_valid = 1'b0;
                        end
                        OP_SLEEP: begin
                            if (i_q_cmd.run_ok) begin
                                wk_we      = 1'b1;
                                wk_addr    = i_q_cmd.rp[IDX_W-1:0];
                                wk_val     = r_os_time + TIME_W'(i_q_cmd.ticks);
                                st_we      = 1'b1;
                                st_addr    = i_q_cmd.rp[IDX_W-1:0];
                                st_val     = ST_SLEEP;
                                n_pend_clr = 1'b1;
                            end
                        end
                        OP_WAIT: begin
                            if (r_sem_count != '0) begin
                                n_sem_count = r_sem_count - SEM_COUNT_W'(1);
                            end else if (i_q_cmd.run_ok
                                         && (r_sem_fill < SEM_FILL_W'(WAITQ_DEPTH))) begin
                                wq_we      = 1'b1;
                                n_sem_tail = r_sem_tail + WQ_PTR_W'(1);
                                n_sem_fill = r_sem_fill + SEM_FILL_W'(1);
                                st_we      = 1'b1;
                                st_addr    = i_q_cmd.rp[IDX_W-1:0];
                                st_val     = ST_WAIT;
                                n_pend_clr = 1'b1;
                            end
                        end
                        OP_POST: begin
                            if (r_sem_fill == '0) begin
                                if (r_sem_count != SEM_COUNT_MAX) begin
                                    n_sem_count = r_sem_count + SEM_COUNT_W'(1);
                                end
                            end else begin
                                n_sem_head  = r_sem_head + WQ_PTR_W'(1);
                                n_sem_fill  = r_sem_fill - SEM_FILL_W'(1);
                                st_we       = w_head_ok;
                                st_addr     = w_head_pid[IDX_W-1:0];
                                st_val      = ST_READY;
                                n_pend_code = CODE_READY;
                                n_pend_pid  = w_head_pid;
                            end
                        end
                        OP_CREATE: begin
                            st_we   = 1'b1;
                            st_addr = i_q_cmd.tp[IDX_W-1:0];
                            st_val  = ST_READY;
                            wk_we   = 1'b1;
                            wk_addr = i_q_cmd.tp[IDX_W-1:0];
                            wk_val  = '0;
                            rt_we   = 1'b1;
                            rt_addr = i_q_cmd.tp[IDX_W-1:0];
                            rt_val  = '0;
                            // slot zero is the idle process and is never queued
                            if (i_q_cmd.tp != '0) begin
                                n_pend_code = CODE_READY;
                                n_pend_pid  = i_q_cmd.tp;
                            end
                        end
                        OP_BADSEM: begin
                            n_pend_code = CODE_BADSEM;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            B_SCAN: begin
                if (w_scan_hit) begin
                    if (w_pend_free) begin
                        st_we   = 1'b1;
                        st_addr = r_idx;
                        st_val  = ST_READY;
                        // the held result is not the final one, so it goes out now
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_code  = r_pend_code;
                            n_out_pid   = r_pend_pid;
                            n_out_clr   = r_pend_clr;
                            n_out_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_code  = CODE_READY;
                        n_pend_pid   = PID_W'(r_idx);
                        n_pend_clr   = 1'b0;
                        n_idx        = r_idx + IDX_W'(1);
                    end
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            B_RUN: begin
                if (w_run_tick) begin
                    if (w_preempt) begin
                        if (w_pend_free) begin
                            st_we   = 1'b1;
                            st_addr = w_run_addr;
                            st_val  = ST_READY;
                            rt_we   = 1'b1;
                            rt_addr = w_run_addr;
                            rt_val  = '0;
                            if (r_pend_valid) begin
                                n_out_valid = 1'b1;
                                n_out_code  = r_pend_code;
                                n_out_pid   = r_pend_pid;
                                n_out_clr   = r_pend_clr;
                                n_out_last  = 1'b0;
                            end
                            n_pend_valid = 1'b1;
                            n_pend_code  = CODE_READY;
                            n_pend_pid   = r_cmd.rp;
                            n_pend_clr   = 1'b1;
                        end
                    end else begin
                        rt_we   = 1'b1;
                        rt_addr = w_run_addr;
                        rt_val  = w_run_next;
                    end
                end
                // nothing readied during the whole tick
                if (!r_pend_valid && !(w_run_tick && w_preempt)) begin
                    n_pend_valid = 1'b1;
                    n_pend_code  = CODE_DONE;
                    n_pend_pid   = '0;
                    n_pend_clr   = 1'b0;
                end
            end
            B_FLUSH: begin
                if (w_can_push) begin
                    n_out_valid  = 1'b1;
                    n_out_code   = r_pend_code;
                    n_out_pid    = r_pend_pid;
                    n_out_clr    = r_pend_clr;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_os_time    <= '0;
            r_sem_count  <= SEM_INIT_RESET;
            r_sem_head   <= '0;
            r_sem_tail   <= '0;
            r_sem_fill   <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_os_time    <= n_os_time;
            r_sem_count  <= n_sem_count;
            r_sem_head   <= n_sem_head;
            r_sem_tail   <= n_sem_tail;
            r_sem_fill   <= n_sem_fill;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_idx       <= n_idx;
        r_pend_code <= n_pend_code;
        r_pend_pid  <= n_pend_pid;
        r_pend_clr  <= n_pend_clr;
        r_out_code  <= n_out_code;
        r_out_pid   <= n_out_pid;
        r_out_clr   <= n_out_clr;
        r_out_last  <= n_out_last;
    end

    // process table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_status[i] <= ST_READY;
                r_wake[i]   <= '0;
                r_run[i]    <= '0;
            end
        end else begin
            if (st_we) begin
                r_status[st_addr] <= st_val;
            end
            if (wk_we) begin
                r_wake[wk_addr] <= wk_val;
            end
            if (rt_we) begin
                r_run[rt_addr] <= rt_val;
            end
        end
    end

    // waiter ring, entries are only read after being written
    always_ff @(posedge i_clk) begin
        if (wq_we) begin
            r_waiters[r_sem_tail] <= i_q_cmd.rp;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_code     = r_out_code;
    assign o_out_pid      = r_out_pid;
    assign o_out_cleared  = r_out_clr;
    assign o_out_last     = r_out_last;
    assign o_stat.sem_fill  = r_sem_fill;
    assign o_stat.sem_count = r_sem_count;

endmodule

// ----- tb/sv/tb.sv -----
// testbench for the tick, sleep and semaphore scheduler: directed and random commands
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsss_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int PROCS = PROC_COUNT_DEF;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_ITEMS = 215;
    localparam logic [KIND_W-1:0] KIND_FIRST_UNUSED = 3'd5;
    localparam logic [KIND_W-1:0] KIND_LAST_UNUSED = 3'd7;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [PID_W-1:0]  pid;
        logic              cleared;
        logic              last;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [IN_USER_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic m_axis_tlast;
    logic i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // scheduler state as the testbench sees it
    logic [TIME_W-1:0]      sched_time;
    logic [STATUS_W-1:0]    proc_state[PROCS];
    logic [TIME_W-1:0]      due_time[PROCS];
    logic [SLICE_W-1:0]     slice_used[PROCS];
    logic [SEM_COUNT_W-1:0] sem_tokens;
    logic [PID_W-1:0]       waiter_fifo[$];
    logic [SLICE_W-1:0]     cfg_slice = SLICE_LIMIT_RESET;
    logic [SEM_ID_W-1:0]    cfg_sem_id = SEM_ID_RESET;

    t_answer answer_q[$];
    int fail_count = 0;
    int cycle_count = 0;

    // sender and receiver pacing
    int burst_left = 0;
    bit gapless = 1'b0;
    int hold_request = 0;
    int hold_left = 0;
    int pattern_left = 0;
    logic [31:0] ready_mask = '1;

    tick_sleep_semaphore_scheduler uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: long hold-off on request, otherwise a changing stall pattern
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(8, 48);
                case ($urandom_range(0, 3))
                    0: ready_mask = '1;
                    1: ready_mask = $urandom;
                    2: ready_mask = $urandom | $urandom;
                    default: ready_mask = $urandom & $urandom;
                endcase
            end
            pattern_left--;
            m_axis_tready <= ready_mask[pattern_left % 32];
        end
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (answer_q.size() == 0) begin
                $error("result beat with nothing expected: code %0d, ready_pid %0d",
                       m_axis_tuser, m_axis_tdata[PID_W-1:0]);
                fail_count++;
            end else begin
                want = answer_q.pop_front();
                if (m_axis_tuser !== want.code) begin
                    $error("code: expected %0d, got %0d", want.code, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[PID_W-1:0] !== want.pid) begin
                    $error("ready_pid: expected %0d, got %0d", want.pid,
                           m_axis_tdata[PID_W-1:0]);
                    fail_count++;
                end
                if (m_axis_tdata[PID_W] !== want.cleared) begin
                    $error("running_cleared: expected %0d, got %0d", want.cleared,
                           m_axis_tdata[PID_W]);
                    fail_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    // works out the result beats of one command and updates the scheduler state
    function automatic void apply_command(input logic [KIND_W-1:0] kind,
                                          input logic [PID_W-1:0] rp, input logic has,
                                          input logic [PID_W-1:0] tp,
                                          input logic [TICKS_W-1:0] ticks,
                                          input logic [SEM_ID_W-1:0] sn);
        t_answer fresh[$];
        t_answer beat;
        logic [PID_W-1:0] woken;
        case (kind)
            KIND_TICK: begin
                sched_time = sched_time + 1;
                for (int p = 0; p < PROCS; p++) begin
                    if (proc_state[p] == ST_SLEEP && due_time[p] <= sched_time) begin
                        proc_state[p] = ST_READY;
                        fresh.push_back('{CODE_READY, PID_W'(p), 1'b0, 1'b0});
                    end
                end
                if (has && rp != 0) begin
                    slice_used[rp] = slice_used[rp] + 16'd1;
                    if (slice_used[rp] >= cfg_slice) begin
                        proc_state[rp] = ST_READY;
                        slice_used[rp] = '0;
                        fresh.push_back('{CODE_READY, rp, 1'b1, 1'b0});
                    end
                end
                if (fresh.size() == 0) fresh.push_back('{CODE_DONE, 4'd0, 1'b0, 1'b0});
            end
            KIND_SLEEP: begin
                if (has) begin
                    due_time[rp] = sched_time + ticks;
                    proc_state[rp] = ST_SLEEP;
                end
                fresh.push_back('{CODE_DONE, 4'd0, has, 1'b0});
            end
            KIND_WAIT: begin
                if (sn != cfg_sem_id) begin
                    fresh.push_back('{CODE_BADSEM, 4'd0, 1'b0, 1'b0});
                end else if (sem_tokens != 0) begin
                    sem_tokens--;
                    fresh.push_back('{CODE_DONE, 4'd0, 1'b0, 1'b0});
                end else if (has && waiter_fifo.size() < WAITQ_DEPTH) begin
                    waiter_fifo.push_back(rp);
                    proc_state[rp] = ST_WAIT;
                    fresh.push_back('{CODE_DONE, 4'd0, 1'b1, 1'b0});
                end else begin
                    fresh.push_back('{CODE_DONE, 4'd0, 1'b0, 1'b0});
                end
            end
            KIND_POST: begin
                if (sn != cfg_sem_id) begin
                    fresh.push_back('{CODE_BADSEM, 4'd0, 1'b0, 1'b0});
                end else if (waiter_fifo.size() == 0) begin
                    if (sem_tokens != SEM_COUNT_MAX) sem_tokens++;
                    fresh.push_back('{CODE_DONE, 4'd0, 1'b0, 1'b0});
                end else begin
                    woken = waiter_fifo.pop_front();
                    proc_state[woken] = ST_READY;
                    fresh.push_back('{CODE_READY, woken, 1'b0, 1'b0});
                end
            end
            KIND_CREATE: begin
                proc_state[tp] = ST_READY;
                due_time[tp] = '0;
                slice_used[tp] = '0;
                if (tp != 0) fresh.push_back('{CODE_READY, tp, 1'b0, 1'b0});
                else fresh.push_back('{CODE_DONE, 4'd0, 1'b0, 1'b0});
            end
            default: fresh.push_back('{CODE_DONE, 4'd0, 1'b0, 1'b0});
        endcase
        foreach (fresh[j]) begin
            beat = fresh[j];
            beat.last = (j == fresh.size() - 1);
            answer_q.push_back(beat);
        end
    endfunction

    function automatic int pick_gap();
        if (gapless) return 0;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) return 0;
        return $urandom_range(1, 6);
    endfunction

    task automatic send_cmd(input logic [KIND_W-1:0] kind, input logic [PID_W-1:0] rp,
                            input logic has, input logic [PID_W-1:0] tp,
                            input logic [TICKS_W-1:0] ticks,
                            input logic [SEM_ID_W-1:0] sn);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {3'b000, sn, ticks, tp, has, rp};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        apply_command(kind, rp, has, tp, ticks, sn);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        wait_drain();
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        case (addr)
            CFG_SLICE_LIMIT: cfg_slice = data;
            CFG_SEM_ID: cfg_sem_id = data[SEM_ID_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reset_dut();
        sched_time = '0;
        for (int p = 0; p < PROCS; p++) begin
            proc_state[p] = ST_READY;
            due_time[p] = '0;
            slice_used[p] = '0;
        end
        sem_tokens = SEM_INIT_RESET;
        waiter_fifo.delete();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic test_create_and_tick();
        send_cmd(KIND_CREATE, 4'd0, 1'b0, 4'd0, 16'd0, 4'd0);
        send_cmd(KIND_CREATE, 4'd15, 1'b1, 4'd15, 16'hFFFF, 4'd15);
        send_cmd(KIND_CREATE, 4'd0, 1'b0, 4'd3, 16'd0, 4'd0);
        send_cmd(KIND_TICK, 4'd5, 1'b0, 4'd0, 16'd0, 4'd0);
        send_cmd(KIND_TICK, 4'd0, 1'b1, 4'd0, 16'd0, 4'd0);
    endtask

    task automatic test_sleep_and_wake();
        send_cmd(KIND_SLEEP, 4'd3, 1'b1, 4'd0, 16'd0, 4'd0);
        send_cmd(KIND_SLEEP, 4'd15, 1'b1, 4'd0, 16'hFFFF, 4'd0);
        send_cmd(KIND_SLEEP, 4'd7, 1'b0, 4'd0, 16'd1, 4'd0);
        send_cmd(KIND_TICK, 4'd0, 1'b0, 4'd0, 16'd0, 4'd0);
        send_cmd(KIND_TICK, 4'd1, 1'b1, 4'd0, 16'd0, 4'd0);
    endtask

    task automatic test_semaphore();
        send_cmd(KIND_WAIT, 4'd5, 1'b1, 4'd0, 16'd0, cfg_sem_id);
        send_cmd(KIND_WAIT, 4'd6, 1'b1, 4'd0, 16'd0, cfg_sem_id);
        send_cmd(KIND_WAIT, 4'd7, 1'b1, 4'd0, 16'd0, cfg_sem_id);
        send_cmd(KIND_POST, 4'd1, 1'b1, 4'd0, 16'd0, cfg_sem_id);
        send_cmd(KIND_POST, 4'd1, 1'b1, 4'd0, 16'd0, cfg_sem_id);
        send_cmd(KIND_POST, 4'd1, 1'b1, 4'd0, 16'd0, cfg_sem_id);
        send_cmd(KIND_WAIT, 4'd2, 1'b1, 4'd0, 16'd0, 4'd15);
        send_cmd(KIND_POST, 4'd2, 1'b1, 4'd0, 16'd0, 4'd0);
        send_cmd(KIND_WAIT, 4'd2, 1'b1, 4'd0, 16'd0, cfg_sem_id);
        // count is zero now, but nobody runs to block
        send_cmd(KIND_WAIT, 4'd9, 1'b0, 4'd0, 16'd0, cfg_sem_id);
    endtask

    task automatic test_spare_kinds();
        for (int k = KIND_FIRST_UNUSED; k <= KIND_LAST_UNUSED; k++)
            send_cmd(KIND_W'(k), '1, 1'b1, '1, '1, '1);
    endtask

    task automatic test_register_settings();
        write_reg(CFG_SLICE_LIMIT, 16'd1);
        send_cmd(KIND_TICK, 4'd4, 1'b1, 4'd0, 16'd0, 4'd0);
        write_reg(CFG_SLICE_LIMIT, 16'hFFFF);
        send_cmd(KIND_TICK, 4'd9, 1'b1, 4'd0, 16'd0, 4'd0);
        send_cmd(KIND_TICK, 4'd9, 1'b1, 4'd0, 16'd0, 4'd0);
        // lowering the limit below the used count preempts on the next tick
        write_reg(CFG_SLICE_LIMIT, 16'd1);
        send_cmd(KIND_TICK, 4'd9, 1'b1, 4'd0, 16'd0, 4'd0);
        write_reg(CFG_SEM_ID, 16'd15);
        write_reg(CFG_SEM_INITIAL, 16'd255);
        send_cmd(KIND_POST, 4'd8, 1'b1, 4'd0, 16'd0, 4'd15);
        send_cmd(KIND_WAIT, 4'd8, 1'b1, 4'd0, 16'd0, 4'd1);
        write_reg(CFG_SEM_ID, 16'd0);
        write_reg(CFG_SEM_INITIAL, 16'd0);
        send_cmd(KIND_WAIT, 4'd8, 1'b1, 4'd0, 16'd0, 4'd0);
        write_reg(CFG_SLICE_LIMIT, SLICE_LIMIT_RESET);
        write_reg(CFG_SEM_ID, CFG_DATA_W'(SEM_ID_RESET));
    endtask

    task automatic test_random_traffic();
        int roll;
        logic [PID_W-1:0] cur_pid;
        logic [KIND_W-1:0] kind;
        logic [PID_W-1:0] rp;
        logic [TICKS_W-1:0] ticks;
        logic [SEM_ID_W-1:0] sn;
        cur_pid = PID_W'($urandom_range(1, 15));
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 59) begin
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_SLICE_LIMIT, 16'd1);
                    1: write_reg(CFG_SLICE_LIMIT, 16'hFFFF);
                    default: write_reg(CFG_SLICE_LIMIT, CFG_DATA_W'($urandom_range(2, 8)));
                endcase
                write_reg(CFG_SEM_ID, CFG_DATA_W'($urandom_range(0, 15)));
                write_reg(CFG_SEM_INITIAL, CFG_DATA_W'($urandom_range(0, 255)));
            end
            // receiver holds off long while the sender keeps offering
            if (n == 80) begin
                hold_request = 300;
                gapless = 1'b1;
            end
            if (n == 105) gapless = 1'b0;
            if (n == 160) wait_drain();
            if ($urandom_range(0, 7) == 0) cur_pid = PID_W'($urandom_range(0, 15));
            rp = ($urandom_range(0, 3) == 0) ? PID_W'($urandom_range(0, 15)) : cur_pid;
            ticks = ($urandom_range(0, 4) == 0) ? TICKS_W'($urandom)
                                                : TICKS_W'($urandom_range(0, 6));
            sn = ($urandom_range(0, 99) < 85) ? cfg_sem_id
                                              : SEM_ID_W'($urandom_range(0, 15));
            roll = $urandom_range(0, 99);
            if (roll < 35) kind = KIND_TICK;
            else if (roll < 50) kind = KIND_SLEEP;
            else if (roll < 65) kind = KIND_WAIT;
            else if (roll < 80) kind = KIND_POST;
            else if (roll < 95) kind = KIND_CREATE;
            else kind = KIND_W'($urandom_range(KIND_FIRST_UNUSED, KIND_LAST_UNUSED));
            send_cmd(kind, rp, $urandom_range(0, 7) != 0, PID_W'($urandom_range(0, 15)),
                     ticks, sn);
        end
    endtask

    task automatic test_waiter_overflow();
        while (sem_tokens != 0)
            send_cmd(KIND_WAIT, PID_W'($urandom_range(0, 15)), 1'b1, 4'd0, 16'd0,
                     cfg_sem_id);
        // one more blocking wait than the waiter fifo holds
        repeat (WAITQ_DEPTH + 1)
            send_cmd(KIND_WAIT, PID_W'($urandom_range(0, 15)), 1'b1,
                     PID_W'($urandom_range(0, 15)), TICKS_W'($urandom), cfg_sem_id);
        repeat (WAITQ_DEPTH + 1)
            send_cmd(KIND_POST, PID_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                     4'd0, 16'd0, cfg_sem_id);
    endtask

    initial begin
        reset_dut();
        test_create_and_tick();
        test_sleep_and_wake();
        test_semaphore();
        test_spare_kinds();
        test_register_settings();
        test_random_traffic();
        test_waiter_overflow();
        wait_drain();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule
